/* hdl/positional_list_engine_core_defines.svh */
// Assertion macros used by the positional list engine checker.
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ple check failed");

// Next-cycle implication, disabled during reset.
`define PLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ple check failed");

`endif

/* hdl/ple_pkg.sv */
// Shared types, constants and helpers of the positional list engine.
package ple_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int WAIT_W = 3;
  localparam int FAN_IN = 8;

  typedef enum logic [2:0] {
    REQ_CLEAR      = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_PUSH_BACK  = 3'd2,
    REQ_INSERT     = 3'd3,
    REQ_ERASE      = 3'd4,
    REQ_FILL       = 3'd5,
    REQ_SWAP       = 3'd6,
    REQ_READ       = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    COP_HOLD,
    COP_CLEAR,
    COP_INSERT,
    COP_ERASE,
    COP_FILL,
    COP_SWAP
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY,
    S_TAIL
  } state_e;

  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] val_a;
    logic [DATA_W-1:0] val_b;
  } cell_ctl_t;

  function automatic int tree_levels(input int n);
    int m;
    int lv;
    m  = n;
    lv = 1;
    for (int k = 0; k < 8; k++) begin
      if (m > FAN_IN) begin
        m  = (m + FAN_IN - 1) >> 3;
        lv = lv + 1;
      end
    end
    return lv;
  endfunction

endpackage

/* hdl/ple_ortree.sv */
// Registered OR-reduction tree that collects the one selected cell tap.
module ple_ortree #(
  parameter int N = 64,
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic [W-1:0] in_i [N],
  output logic [W-1:0] out_o
);

  localparam int FAN = ple_pkg::FAN_IN;

  if (N <= FAN) begin : g_leaf
    logic [W-1:0] red_d;
    logic [W-1:0] red_q;

    always_comb begin
      red_d = '0;
      for (int k = 0; k < N; k++) begin
        red_d = red_d | in_i[k];
      end
    end

    always_ff @(posedge clk_i) begin
      red_q <= red_d;
    end

    assign out_o = red_q;
  end else begin : g_node
    localparam int NG = (N + FAN - 1) / FAN;
    logic [W-1:0] grp_q [NG];

    for (genvar g = 0; g < NG; g++) begin : g_grp
      logic [W-1:0] grp_d;
      always_comb begin
        grp_d = '0;
        for (int k = 0; k < FAN; k++) begin
          if (g * FAN + k < N) begin
            grp_d = grp_d | in_i[g * FAN + k];
          end
        end
      end
      always_ff @(posedge clk_i) begin
        grp_q[g] <= grp_d;
      end
    end

    ple_ortree #(.N(NG), .W(W)) u_sub (
      .clk_i (clk_i),
      .in_i  (grp_q),
      .out_o (out_o)
    );
  end

endmodule

/* hdl/ple_cell.sv */
// One list cell: holds an entry and updates it from its neighbors.
module ple_cell #(
  parameter int IDX_W = 7,
  parameter int INDEX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ple_pkg::cell_ctl_t        ctl_i,
  input  logic [IDX_W-1:0]          slot_i,
  input  logic [IDX_W-1:0]          sel_a_i,
  input  logic [IDX_W-1:0]          sel_b_i,
  input  logic [ple_pkg::DATA_W-1:0] left_i,
  input  logic [ple_pkg::DATA_W-1:0] right_i,
  output logic [ple_pkg::DATA_W-1:0] entry_o,
  output logic [ple_pkg::DATA_W-1:0] tap_a_o,
  output logic [ple_pkg::DATA_W-1:0] tap_b_o
);
  import ple_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_W-1:0] entry_d;
  logic [DATA_W-1:0] entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      COP_HOLD: entry_d = entry_q;
      COP_CLEAR: entry_d = '0;
      COP_INSERT: begin
        if (MY_IDX == slot_i) begin
          entry_d = ctl_i.val;
        end else if (MY_IDX > slot_i) begin
          entry_d = left_i;
        end
      end
      COP_ERASE: begin
        if (MY_IDX >= slot_i) begin
          entry_d = right_i;
        end
      end
      COP_FILL: begin
        if (MY_IDX < slot_i) begin
          entry_d = ctl_i.val;
        end
      end
      COP_SWAP: begin
        if (MY_IDX == sel_a_i) begin
          entry_d = ctl_i.val_b;
        end else if (MY_IDX == sel_b_i) begin
          entry_d = ctl_i.val_a;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign tap_a_o = (MY_IDX == sel_a_i) ? entry_q : '0;
  assign tap_b_o = (MY_IDX == sel_b_i) ? entry_q : '0;

endmodule

/* hdl/positional_list_engine_core.sv */
// Top level of the positional list engine: control, cell chain and readout trees.
//
//  channel  | handshake                 | fields
//  ---------+---------------------------+---------------------------------------------
//  request  | start, busy (beat: start & !busy) | req_type, position, second_position, value
//  result   | done_o strobe, one cycle  | read_value, front_value, back_value, count,
//           |                           | is_empty, error
//
// A beat runs through S_LOOK, S_APPLY and S_TAIL before the next is accepted.
// S_LOOK and S_TAIL wait on the 8-ary readout trees, L levels deep (L=2 at 64 cells).
// The trees are walked twice: once to fetch entries, once for the last entry.
// Reset clears every cell and the count at once; no sweep follows.
// The result strobe cannot be held off; a new beat is taken in the strobe cycle.
module positional_list_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        req_type_i,
  input  logic [ple_pkg::POS_W-1:0]         position_i,
  input  logic [ple_pkg::POS_W-1:0]         second_position_i,
  input  logic signed [ple_pkg::DATA_W-1:0] value_i,
  output logic                              done_o,
  output logic signed [ple_pkg::DATA_W-1:0] read_value_o,
  output logic signed [ple_pkg::DATA_W-1:0] front_value_o,
  output logic signed [ple_pkg::DATA_W-1:0] back_value_o,
  output logic [ple_pkg::POS_W-1:0]         count_o,
  output logic                              is_empty_o,
  output logic                              error_o
);
  import ple_pkg::*;

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int LAT = tree_levels(CAPACITY);

  state_e             state_q, state_d;
  logic [WAIT_W-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]      count_q, count_d;
  logic               done_q;

  req_e               kind_q;
  logic               err_q;
  logic [CW-1:0]      slot_q;
  logic [CW-1:0]      sel_a_q, sel_a_d;
  logic [CW-1:0]      sel_b_q, sel_b_d;
  logic [DATA_W-1:0]  val_q, va_q, vb_q, rd_q;
  logic [DATA_W-1:0]  read_q, front_q, back_q;
  logic [CW-1:0]      out_count_q;
  logic               empty_q, error_q;

  logic               acc_err;
  logic [XW-1:0]      acc_slot;
  logic [XW-1:0]      p1x, p2x, cx, capx, out_cx;
  logic               full, p1_in, p2_in;
  logic               accept, wait_done;

  cell_ctl_t          ctl;
  logic [DATA_W-1:0]  ent   [CAPACITY];
  logic [DATA_W-1:0]  tap_a [CAPACITY];
  logic [DATA_W-1:0]  tap_b [CAPACITY];
  logic [DATA_W-1:0]  tree_a, tree_b;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign wait_done = (cnt_q == WAIT_W'(LAT));

  // request check
  always_comb begin
    p1x      = XW'(position_i);
    p2x      = XW'(second_position_i);
    cx       = XW'(count_q);
    capx     = XW'(CAPACITY);
    full     = (cx == capx);
    p1_in    = (p1x != '0) && (p1x <= cx);
    p2_in    = (p2x != '0) && (p2x <= cx);
    acc_err  = 1'b0;
    acc_slot = p1x - XW'(1);
    unique case (req_e'(req_type_i))
      REQ_CLEAR: acc_err = 1'b0;
      REQ_PUSH_FRONT: begin
        acc_err  = full;
        acc_slot = '0;
      end
      REQ_PUSH_BACK: begin
        acc_err  = full;
        acc_slot = cx;
      end
      REQ_INSERT: acc_err = full || (p1x == '0) || (p1x > cx + XW'(1));
      REQ_ERASE: acc_err = !p1_in;
      REQ_FILL: begin
        acc_err  = (p1x == '0) || (p1x > capx);
        acc_slot = p1x;
      end
      REQ_SWAP: acc_err = !p1_in || !p2_in;
      REQ_READ: acc_err = !p1_in;
      default: acc_err = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_LOOK;
      S_LOOK:  if (wait_done) state_d = S_APPLY;
      S_APPLY: state_d = S_TAIL;
      S_TAIL:  if (wait_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // cell control, count and selector updates
  always_comb begin
    ctl.op    = COP_HOLD;
    ctl.val   = val_q;
    ctl.val_a = va_q;
    ctl.val_b = vb_q;
    count_d   = count_q;
    sel_a_d   = sel_a_q;
    sel_b_d   = sel_b_q;
    cnt_d     = (state_d != state_q) ? '0 : cnt_q + WAIT_W'(1);
    if (accept) begin
      sel_a_d = CW'(p1x - XW'(1));
      sel_b_d = CW'(p2x - XW'(1));
    end
    if (state_q == S_APPLY) begin
      if (!err_q) begin
        unique case (kind_q)
          REQ_CLEAR: begin
            ctl.op  = COP_CLEAR;
            count_d = '0;
          end
          REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
            ctl.op  = COP_INSERT;
            count_d = count_q + CW'(1);
          end
          REQ_ERASE: begin
            ctl.op  = COP_ERASE;
            count_d = count_q - CW'(1);
          end
          REQ_FILL: begin
            ctl.op  = COP_FILL;
            count_d = (slot_q > count_q) ? slot_q : count_q;
          end
          REQ_SWAP: ctl.op = COP_SWAP;
          REQ_READ: ctl.op = COP_HOLD;
          default: ctl.op = COP_HOLD;
        endcase
      end
      sel_b_d = count_d - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
      sel_a_q <= '0;
      sel_b_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
      done_q  <= (state_q == S_TAIL) && wait_done;
      sel_a_q <= sel_a_d;
      sel_b_q <= sel_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req_e'(req_type_i);
      err_q  <= acc_err;
      slot_q <= CW'(acc_slot);
      val_q  <= value_i;
    end
    if ((state_q == S_LOOK) && wait_done) begin
      va_q <= tree_a;
      vb_q <= tree_b;
      rd_q <= ((kind_q == REQ_READ) && !err_q) ? tree_a : '0;
    end
    if ((state_q == S_TAIL) && wait_done) begin
      read_q      <= rd_q;
      front_q     <= (count_q == '0) ? '0 : ent[0];
      back_q      <= (count_q == '0) ? '0 : tree_b;
      out_count_q <= count_q;
      empty_q     <= (count_q == '0);
      error_q     <= err_q;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = ent[i+1];
    end
    ple_cell #(.IDX_W(CW), .INDEX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .slot_i  (slot_q),
      .sel_a_i (sel_a_q),
      .sel_b_i (sel_b_q),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (ent[i]),
      .tap_a_o (tap_a[i]),
      .tap_b_o (tap_b[i])
    );
  end

  ple_ortree #(.N(CAPACITY), .W(DATA_W)) u_tree_a (
    .clk_i (clk_i),
    .in_i  (tap_a),
    .out_o (tree_a)
  );

  ple_ortree #(.N(CAPACITY), .W(DATA_W)) u_tree_b (
    .clk_i (clk_i),
    .in_i  (tap_b),
    .out_o (tree_b)
  );

  assign out_cx        = XW'(out_count_q);
  assign done_o        = done_q;
  assign read_value_o  = read_q;
  assign front_value_o = front_q;
  assign back_value_o  = back_q;
  assign count_o       = out_cx[POS_W-1:0];
  assign is_empty_o    = empty_q;
  assign error_o       = error_q;

endmodule

/* hdl/ple_checker.sv */
// Port-level checker for the positional list engine, bound to the top level.
`include "positional_list_engine_core_defines.svh"

module ple_checker #(
  parameter int CAPACITY = 64
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic signed [ple_pkg::DATA_W-1:0] read_value_o,
  input logic signed [ple_pkg::DATA_W-1:0] front_value_o,
  input logic signed [ple_pkg::DATA_W-1:0] back_value_o,
  input logic [ple_pkg::POS_W-1:0]         count_o,
  input logic                              is_empty_o,
  input logic                              error_o
);
  import ple_pkg::*;

  localparam logic [POS_W:0] CAP_X = (POS_W + 1)'(CAPACITY);

  `PLE_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `PLE_ASSERT_IMPL(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy) && !busy)
  `PLE_ASSERT_IMPL(a_empty_flag, clk_i, rst_ni, done_o, is_empty_o == (count_o == '0))
  `PLE_ASSERT_IMPL(a_empty_ends, clk_i, rst_ni, done_o && is_empty_o,
                   front_value_o == '0 && back_value_o == '0)
  `PLE_ASSERT_IMPL(a_count_cap, clk_i, rst_ni, done_o, {1'b0, count_o} <= CAP_X)

endmodule

bind positional_list_engine_core ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

/* bench/tb_positional_list_engine_core.sv */
// Self-checking bench for the positional list engine: directed table, then random beats.
module tb_positional_list_engine_core;
  import ple_pkg::*;

  localparam int CAP = 64;
  localparam int N_DIRECTED = 26;
  localparam int N_PER_PHASE = 375;
  localparam int TAIL_CYCLES = 20;
  localparam logic [31:0] FILLER = 32'hdead_beef;

  typedef struct packed {
    logic [31:0] rd;
    logic [31:0] front;
    logic [31:0] back;
    logic [6:0]  cnt;
    logic        empty;
    logic        err;
  } list_snapshot_t;

  typedef struct packed {
    req_e           req;
    logic [6:0]     pos;
    logic [6:0]     pos2;
    logic [31:0]    val;
    logic           typed;
    list_snapshot_t res;
  } list_beat_t;

  localparam list_snapshot_t EMPTY_ERR = '{32'h0, 32'h0, 32'h0, 7'd0, 1'b1, 1'b1};
  localparam list_snapshot_t FULL_ERR  = '{32'h0, FILLER, FILLER, 7'd64, 1'b0, 1'b1};
  localparam list_snapshot_t NO_RES    = '0;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic [2:0]                        req_type_i;
  logic [POS_W-1:0]                  position_i;
  logic [POS_W-1:0]                  second_position_i;
  logic signed [DATA_W-1:0]          value_i;
  logic                              done_o;
  logic signed [DATA_W-1:0]          read_value_o;
  logic signed [DATA_W-1:0]          front_value_o;
  logic signed [DATA_W-1:0]          back_value_o;
  logic [POS_W-1:0]                  count_o;
  logic                              is_empty_o;
  logic                              error_o;

  logic [31:0]    mirror_entries [CAP];
  int             mirror_count;
  list_snapshot_t snapshot_q [$];
  logic           use_table_result;
  list_snapshot_t table_result;
  int             mismatches;

  list_beat_t directed_tab [N_DIRECTED] = '{
    '{REQ_READ,       7'd1,  7'd0,   32'h0,          1'b1, EMPTY_ERR},
    '{REQ_ERASE,      7'd1,  7'd0,   32'h0,          1'b1, EMPTY_ERR},
    '{REQ_INSERT,     7'd2,  7'd0,   32'h7,          1'b1, EMPTY_ERR},
    '{REQ_FILL,       7'd0,  7'd0,   32'h1,          1'b1, EMPTY_ERR},
    '{REQ_FILL,       7'd65, 7'd0,   32'h1,          1'b1, EMPTY_ERR},
    '{REQ_PUSH_BACK,  7'd0,  7'd0,   32'h7fff_ffff,  1'b1,
      '{32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 7'd1, 1'b0, 1'b0}},
    '{REQ_PUSH_FRONT, 7'd0,  7'd0,   32'h8000_0000,  1'b1,
      '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 7'd2, 1'b0, 1'b0}},
    '{REQ_INSERT,     7'd2,  7'd0,   32'h5,          1'b0, NO_RES},
    '{REQ_INSERT,     7'd4,  7'd0,   32'hffff_ffff,  1'b0, NO_RES},
    '{REQ_READ,       7'd4,  7'd0,   32'h0,          1'b0, NO_RES},
    '{REQ_SWAP,       7'd1,  7'd4,   32'h0,          1'b0, NO_RES},
    '{REQ_SWAP,       7'd2,  7'd2,   32'h0,          1'b0, NO_RES},
    '{REQ_SWAP,       7'd1,  7'd5,   32'h0,          1'b0, NO_RES},
    '{REQ_ERASE,      7'd1,  7'd0,   32'h0,          1'b0, NO_RES},
    '{REQ_ERASE,      7'd3,  7'd0,   32'h0,          1'b0, NO_RES},
    '{REQ_FILL,       7'd64, 7'd0,   FILLER,         1'b1,
      '{32'h0, FILLER, FILLER, 7'd64, 1'b0, 1'b0}},
    '{REQ_PUSH_BACK,  7'd0,  7'd0,   32'h0,          1'b1, FULL_ERR},
    '{REQ_PUSH_FRONT, 7'd0,  7'd0,   32'h0,          1'b1, FULL_ERR},
    '{REQ_INSERT,     7'd1,  7'd0,   32'h0,          1'b1, FULL_ERR},
    '{REQ_READ,       7'd64, 7'd0,   32'h0,          1'b1,
      '{FILLER, FILLER, FILLER, 7'd64, 1'b0, 1'b0}},
    '{REQ_FILL,       7'd3,  7'd0,   32'h1,          1'b0, NO_RES},
    '{REQ_ERASE,      7'd64, 7'd0,   32'h0,          1'b0, NO_RES},
    '{REQ_INSERT,     7'd64, 7'd0,   32'h5555_5555,  1'b0, NO_RES},
    '{REQ_CLEAR,      7'd0,  7'd0,   32'h0,          1'b1,
      '{32'h0, 32'h0, 32'h0, 7'd0, 1'b1, 1'b0}},
    '{REQ_READ,       7'd0,  7'd0,   32'h0,          1'b1, EMPTY_ERR},
    '{REQ_SWAP,       7'd1,  7'd127, 32'h0,          1'b1, EMPTY_ERR}
  };

  positional_list_engine_core #(
    .CAPACITY(CAP)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .second_position_i(second_position_i),
    .value_i          (value_i),
    .done_o           (done_o),
    .read_value_o     (read_value_o),
    .front_value_o    (front_value_o),
    .back_value_o     (back_value_o),
    .count_o          (count_o),
    .is_empty_o       (is_empty_o),
    .error_o          (error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic bit in_list(input int p);
    return p >= 1 && p <= mirror_count;
  endfunction

  function automatic list_snapshot_t apply_request(input req_e req, input logic [6:0] pos,
                                                   input logic [6:0] pos2, input logic [31:0] val);
    list_snapshot_t r;
    logic [31:0] tmp;
    int p;
    int q;
    r = '0;
    p = pos;
    q = pos2;
    case (req)
      REQ_CLEAR: begin
        for (int i = 0; i < CAP; i++) mirror_entries[i] = '0;
        mirror_count = 0;
      end
      REQ_PUSH_FRONT: begin
        if (mirror_count >= CAP) begin
          r.err = 1'b1;
        end else begin
          for (int i = mirror_count; i > 0; i--) mirror_entries[i] = mirror_entries[i-1];
          mirror_entries[0] = val;
          mirror_count++;
        end
      end
      REQ_PUSH_BACK: begin
        if (mirror_count >= CAP) begin
          r.err = 1'b1;
        end else begin
          mirror_entries[mirror_count] = val;
          mirror_count++;
        end
      end
      REQ_INSERT: begin
        if (mirror_count >= CAP || p < 1 || p > mirror_count + 1) begin
          r.err = 1'b1;
        end else begin
          for (int i = mirror_count; i > p - 1; i--) mirror_entries[i] = mirror_entries[i-1];
          mirror_entries[p-1] = val;
          mirror_count++;
        end
      end
      REQ_ERASE: begin
        if (!in_list(p)) begin
          r.err = 1'b1;
        end else begin
          for (int i = p - 1; i + 1 < mirror_count; i++) mirror_entries[i] = mirror_entries[i+1];
          mirror_entries[mirror_count-1] = '0;
          mirror_count--;
        end
      end
      REQ_FILL: begin
        if (p < 1 || p > CAP) begin
          r.err = 1'b1;
        end else begin
          for (int i = 0; i < p; i++) mirror_entries[i] = val;
          if (mirror_count < p) mirror_count = p;
        end
      end
      REQ_SWAP: begin
        if (!in_list(p) || !in_list(q)) begin
          r.err = 1'b1;
        end else begin
          tmp = mirror_entries[p-1];
          mirror_entries[p-1] = mirror_entries[q-1];
          mirror_entries[q-1] = tmp;
        end
      end
      REQ_READ: begin
        if (!in_list(p)) r.err = 1'b1;
        else r.rd = mirror_entries[p-1];
      end
    endcase
    r.front = (mirror_count != 0) ? mirror_entries[0] : '0;
    r.back  = (mirror_count != 0) ? mirror_entries[mirror_count-1] : '0;
    r.cnt   = 7'(mirror_count);
    r.empty = (mirror_count == 0);
    return r;
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic list_beat_t random_beat();
    list_beat_t b;
    int roll;
    int top;
    b = '0;
    roll = $urandom_range(0, 99);
    if (roll < 1) b.req = REQ_CLEAR;
    else if (roll < 13) b.req = REQ_PUSH_FRONT;
    else if (roll < 25) b.req = REQ_PUSH_BACK;
    else if (roll < 43) b.req = REQ_INSERT;
    else if (roll < 58) b.req = REQ_ERASE;
    else if (roll < 64) b.req = REQ_FILL;
    else if (roll < 76) b.req = REQ_SWAP;
    else b.req = REQ_READ;
    top = (mirror_count > 0) ? mirror_count : 1;
    case (b.req)
      REQ_INSERT: b.pos = 7'($urandom_range(1, mirror_count + 1));
      REQ_FILL: begin
        roll = $urandom_range(0, 19);
        if (roll == 0) b.pos = 7'(CAP);
        else if (roll < 3) b.pos = 7'($urandom_range(9, CAP));
        else b.pos = 7'($urandom_range(1, 8));
      end
      default: b.pos = 7'($urandom_range(1, top));
    endcase
    b.pos2 = 7'($urandom_range(1, top));
    if ($urandom_range(0, 99) < 10) b.pos = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 10) b.pos2 = 7'($urandom_range(0, 127));
    b.val = random_value();
    return b;
  endfunction

  task automatic report_fail(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_fail($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Enter and leave at a falling edge; hold the beat until it is taken.
  task automatic drive_beat(input list_beat_t b, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    start             <= 1'b1;
    req_type_i        <= b.req;
    position_i        <= b.pos;
    second_position_i <= b.pos2;
    value_i           <= b.val;
    use_table_result  = b.typed;
    table_result      = b.res;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : monitor
    list_snapshot_t got;
    list_snapshot_t want;
    list_snapshot_t pred;
    if (rst_ni) begin
      if (done_o) begin
        got = '{read_value_o, front_value_o, back_value_o, count_o, is_empty_o, error_o};
        if (snapshot_q.size() == 0) begin
          report_fail($sformatf("result with nothing pending, count %0d", count_o));
        end else begin
          want = snapshot_q.pop_front();
          check_field("read_value", got.rd, want.rd);
          check_field("front_value", got.front, want.front);
          check_field("back_value", got.back, want.back);
          check_field("count", 32'(got.cnt), 32'(want.cnt));
          check_field("is_empty", 32'(got.empty), 32'(want.empty));
          check_field("error", 32'(got.err), 32'(want.err));
        end
      end
      if (start && !busy) begin
        pred = apply_request(req_e'(req_type_i), position_i, second_position_i, value_i);
        snapshot_q.push_back(use_table_result ? table_result : pred);
      end
    end
  end

  initial begin : stimulus
    int pct;
    mismatches        = 0;
    mirror_count      = 0;
    for (int i = 0; i < CAP; i++) mirror_entries[i] = '0;
    use_table_result  = 1'b0;
    table_result      = '0;
    rst_ni            = 1'b0;
    start             = 1'b0;
    req_type_i        = '0;
    position_i        = '0;
    second_position_i = '0;
    value_i           = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    for (int i = 0; i < N_DIRECTED; i++) drive_beat(directed_tab[i], 0);
    for (int ph = 0; ph < 4; ph++) begin
      pct = (ph == 1) ? 49 : (ph == 2) ? 34 : 0;
      start <= 1'b0;
      do @(negedge clk_i); while (snapshot_q.size() != 0);
      for (int n = 0; n < N_PER_PHASE; n++) drive_beat(random_beat(), pct);
    end
    start <= 1'b0;
    while (snapshot_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && snapshot_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_ortree.sv
hdl/ple_cell.sv
hdl/positional_list_engine_core.sv
hdl/ple_checker.sv
bench/tb_positional_list_engine_core.sv
